// ----- rtl/fcb_pkg.sv -----
package fcb_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_SCALE_LIMIT  = 3'd2;
  localparam logic [2:0] REG_SHIFT_X_FRAC = 3'd3;
  localparam logic [2:0] REG_SHIFT_Y_FRAC = 3'd4;

  // Register reset values.
  localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;
  localparam logic [11:0] SCALE_LIMIT_RST  = 12'd1024;

  // The fit ratio numerator is (dim-1) in Q12.8, so 20 bits; one quotient bit per step.
  localparam int unsigned NUM_BITS  = 20;
  localparam int unsigned DIV_STEPS = NUM_BITS;

  // One lane of the restoring divider: partial remainder and the register that
  // shifts numerator bits out and quotient bits in.
  typedef struct packed {
    logic [15:0]         rem;
    logic [NUM_BITS-1:0] quo;
  } div_lane_t;

  // Box data that travels alongside the divider.
  typedef struct packed {
    logic signed [13:0] left;
    logic signed [13:0] top;
    logic [14:0]        bw;
    logic [14:0]        bh;
    logic               inval;
  } box_side_t;

  // Placement of the crop along one axis.
  typedef struct packed {
    logic signed [19:0] lo;
    logic signed [19:0] hi;
    logic [11:0]        len;
  } axis_t;

endpackage

// ----- rtl/face_crop_box_calc_top.sv -----
// Face crop box calculator.
//
// Input channel (in_valid / in_ready) carries one face box item: inclusive
// corners box_left, box_top, box_right and box_bottom. Output channel
// (out_valid / out_ready) carries one result item per box: crop_left,
// crop_top, crop_width, crop_height and box_invalid.
//
// The datapath is a 26-stage pipeline, and one item can be accepted in every
// cycle while the receiver keeps out_ready high. The depth is set by the
// fit-ratio divider, which resolves one quotient bit per stage for both axes
// in parallel (20 stages).
//
// When the receiver stalls, a stage holds its item only if all later stages
// are full too; stages above a bubble advance, so the input keeps accepting
// items until every stage is full. Nothing is dropped or repeated.
//
// Synchronous reset empties the pipeline and loads the configuration
// registers with their defaults (640 x 480 frame, scale 4.0, no shift).
// Configuration is written through cfg_write / cfg_index / cfg_data, one
// register per cycle, and must only change while the pipeline is empty.
module face_crop_box_calc_top
  import fcb_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [2:0]        cfg_index,
  input  logic [11:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [13:0] box_left,
  input  logic signed [13:0] box_top,
  input  logic signed [13:0] box_right,
  input  logic signed [13:0] box_bottom,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [11:0]       crop_left,
  output logic [11:0]       crop_top,
  output logic [11:0]       crop_width,
  output logic [11:0]       crop_height,
  output logic              box_invalid
);

  // Stage map: 0 input register, 1..DIV_STEPS divider steps, then scale
  // select, multiply, placement, slide right, slide left and output.
  localparam int STG_DIV0  = 0;
  localparam int STG_MIN   = DIV_STEPS + 1;
  localparam int STG_MUL   = STG_MIN + 1;
  localparam int STG_PLACE = STG_MUL + 1;
  localparam int STG_SLIDE = STG_PLACE + 1;
  localparam int STG_OUT   = STG_SLIDE + 1;
  localparam int NSTG      = STG_OUT + 1;

  // Upper bound of the crop position clamp.
  localparam logic signed [19:0] CoordMax = 20'((64'd1 << COORD_BITS) - 64'd1);

  // Configuration registers.
  logic [11:0]       frame_width;
  logic [11:0]       frame_height;
  logic [11:0]       scale_limit;
  logic signed [9:0] shift_x_frac;
  logic signed [9:0] shift_y_frac;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      scale_limit  <= SCALE_LIMIT_RST;
      shift_x_frac <= '0;
      shift_y_frac <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_SCALE_LIMIT:  scale_limit  <= cfg_data;
        REG_SHIFT_X_FRAC: shift_x_frac <= cfg_data[9:0];
        REG_SHIFT_Y_FRAC: shift_y_frac <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Valid bits and flow control. A stage may load when out_ready is high or
  // when it or some stage further down is empty, which is a NAND over the valid bits.
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;

  for (genvar i = 0; i < NSTG; i++) begin : g_adv
    assign adv[i] = out_ready || !(&vld[NSTG-1:i]);
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[STG_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // One restoring division step: bring in the next numerator bit and
  // subtract the divisor when it fits.
  function automatic div_lane_t div_step(div_lane_t a, logic [14:0] d);
    div_lane_t          r;
    logic [15:0]        part;
    begin
      part = {a.rem[14:0], a.quo[NUM_BITS-1]};
      if (part >= {1'b0, d}) begin
        r.rem = part - {1'b0, d};
        r.quo = {a.quo[NUM_BITS-2:0], 1'b1};
      end else begin
        r.rem = part;
        r.quo = {a.quo[NUM_BITS-2:0], 1'b0};
      end
      return r;
    end
  endfunction

  // Stage 0: box size, validity and divider setup.
  logic signed [15:0] bw_in;
  logic signed [15:0] bh_in;
  logic               inval_in;
  logic [11:0]        dx_in;
  logic [11:0]        dy_in;

  always_comb begin
    bw_in    = 16'(box_right) - 16'(box_left) + 16'sd1;
    bh_in    = 16'(box_bottom) - 16'(box_top) + 16'sd1;
    inval_in = bw_in[15] || (bw_in == 16'sd0) || bh_in[15] || (bh_in == 16'sd0);
    // A zero frame register counts as a dimension minus one of zero.
    dx_in    = (frame_width == 12'd0) ? 12'd0 : frame_width - 12'd1;
    dy_in    = (frame_height == 12'd0) ? 12'd0 : frame_height - 12'd1;
  end

  box_side_t side [0:DIV_STEPS];
  div_lane_t lane_x [0:DIV_STEPS];
  div_lane_t lane_y [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (adv[STG_DIV0]) begin
      side[0].left  <= box_left;
      side[0].top   <= box_top;
      // An invalid box divides by one; its result is forced to zero later.
      side[0].bw    <= inval_in ? 15'd1 : bw_in[14:0];
      side[0].bh    <= inval_in ? 15'd1 : bh_in[14:0];
      side[0].inval <= inval_in;
      lane_x[0].rem <= '0;
      lane_x[0].quo <= {dx_in, 8'h00};
      lane_y[0].rem <= '0;
      lane_y[0].quo <= {dy_in, 8'h00};
    end
  end

  // Divider stages, one quotient bit each.
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv[k]) begin
        side[k]   <= side[k-1];
        lane_x[k] <= div_step(lane_x[k-1], side[k-1].bw);
        lane_y[k] <= div_step(lane_y[k-1], side[k-1].bh);
      end
    end
  end

  // Scale select: smallest of the limit and the two fit ratios.
  logic [11:0] scale_sel;
  logic [11:0] scale_min;
  box_side_t   side_min;

  always_comb begin
    scale_sel = scale_limit;
    if (lane_x[DIV_STEPS].quo < {8'h00, scale_sel}) begin
      scale_sel = lane_x[DIV_STEPS].quo[11:0];
    end
    if (lane_y[DIV_STEPS].quo < {8'h00, scale_sel}) begin
      scale_sel = lane_y[DIV_STEPS].quo[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[STG_MIN]) begin
      scale_min <= scale_sel;
      side_min  <= side[DIV_STEPS];
    end
  end

  // Multiply: crop length products and shift products.
  logic [26:0]        len_px;
  logic [26:0]        len_py;
  logic signed [25:0] sh_px;
  logic signed [25:0] sh_py;
  box_side_t          side_mul;

  always_ff @(posedge clk) begin
    if (adv[STG_MUL]) begin
      len_px   <= 27'(side_min.bw) * 27'(scale_min);
      len_py   <= 27'(side_min.bh) * 27'(scale_min);
      sh_px    <= 26'($signed({1'b0, side_min.bw})) * 26'(shift_x_frac);
      sh_py    <= 26'($signed({1'b0, side_min.bh})) * 26'(shift_y_frac);
      side_mul <= side_min;
    end
  end

  // Placement about the box centre. The length never exceeds dim-1, so
  // twelve bits hold it. The shift is truncated toward zero.
  function automatic axis_t place(logic signed [13:0] start, logic [14:0] size,
                                  logic [26:0] len_p, logic signed [25:0] sh_p);
    axis_t              r;
    logic signed [25:0] sh_adj;
    logic signed [19:0] shift;
    logic signed [19:0] centre;
    logic signed [19:0] half;
    begin
      sh_adj = sh_p[25] ? sh_p + 26'sd255 : sh_p;
      shift  = 20'(sh_adj >>> 8);
      centre = 20'(start) + $signed({6'b0, size[14:1]});
      r.len  = len_p[19:8];
      half   = $signed({9'b0, r.len[11:1]});
      r.lo   = centre - half + shift;
      r.hi   = centre + half + shift;
      return r;
    end
  endfunction

  axis_t ax_place;
  axis_t ay_place;
  logic  inval_place;

  always_ff @(posedge clk) begin
    if (adv[STG_PLACE]) begin
      ax_place    <= place(side_mul.left, side_mul.bw, len_px, sh_px);
      ay_place    <= place(side_mul.top, side_mul.bh, len_py, sh_py);
      inval_place <= side_mul.inval;
    end
  end

  // Slide right so that the low corner is not negative.
  function automatic axis_t slide_right(axis_t a);
    axis_t r;
    begin
      r = a;
      if (a.lo < 20'sd0) begin
        r.hi = a.hi - a.lo;
        r.lo = 20'sd0;
      end
      return r;
    end
  endfunction

  axis_t ax_slide;
  axis_t ay_slide;
  logic  inval_slide;

  always_ff @(posedge clk) begin
    if (adv[STG_SLIDE]) begin
      ax_slide    <= slide_right(ax_place);
      ay_slide    <= slide_right(ay_place);
      inval_slide <= inval_place;
    end
  end

  // Slide left so that the high corner is inside the frame, then clamp the
  // start coordinate.
  function automatic logic [11:0] slide_left(axis_t a, logic [11:0] dim);
    logic signed [19:0] lo;
    logic signed [19:0] d;
    begin
      d  = $signed({8'b0, dim});
      lo = a.lo;
      if (a.hi >= d) begin
        lo = a.lo - (a.hi - d + 20'sd1);
      end
      if (lo < 20'sd0) begin
        lo = 20'sd0;
      end
      if (lo > CoordMax) begin
        lo = CoordMax;
      end
      return lo[11:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (adv[STG_OUT]) begin
      if (inval_slide) begin
        crop_left   <= '0;
        crop_top    <= '0;
        crop_width  <= '0;
        crop_height <= '0;
      end else begin
        crop_left   <= slide_left(ax_slide, frame_width);
        crop_top    <= slide_left(ay_slide, frame_height);
        crop_width  <= ax_slide.len;
        crop_height <= ay_slide.len;
      end
      box_invalid <= inval_slide;
    end
  end

endmodule

// ----- verif/fcb_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels and the register port of the crop box calculator,
// predicts each crop rectangle and compares it with what comes out.
module fcb_checker
  import fcb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [11:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [13:0] box_left,
  input  logic signed [13:0] box_top,
  input  logic signed [13:0] box_right,
  input  logic signed [13:0] box_bottom,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [11:0]        crop_left,
  input  logic [11:0]        crop_top,
  input  logic [11:0]        crop_width,
  input  logic [11:0]        crop_height,
  input  logic               box_invalid,
  output int                 fail_count,
  output int                 pending,
  output int                 checked_count,
  output int                 invalid_count
);

  localparam int COORD_BITS = 12;

  typedef struct packed {
    logic [11:0] left;
    logic [11:0] top;
    logic [11:0] width;
    logic [11:0] height;
    logic        invalid;
  } crop_t;

  logic [11:0]       frame_w;
  logic [11:0]       frame_h;
  logic [11:0]       scale_cap;
  logic signed [9:0] shift_x;
  logic signed [9:0] shift_y;

  crop_t crops_due[$];
  int    fails = 0;
  int    checked = 0;
  int    invalids = 0;

  // Largest Q4.8 enlargement that keeps size inside dim; a zero dim gives zero.
  function automatic longint fit_scale(input logic [11:0] dim, input longint size);
    longint span;
    span = (dim == 0) ? 0 : longint'(dim) - 1;
    return (span * 256) / size;
  endfunction

  function automatic logic [11:0] clamp_pos(input longint v);
    longint top_val;
    top_val = (longint'(1) << COORD_BITS) - 1;
    if (v < 0) v = 0;
    if (v > top_val) v = top_val;
    return v[11:0];
  endfunction

  // Start of the crop along one axis; len gets the crop length.
  function automatic longint place_span(input longint start, input longint size,
                                        input longint scale, input longint frac,
                                        input logic [11:0] dim, output longint len);
    longint n, centre, offset, lo, hi;
    n      = (size * scale) / 256;
    centre = size / 2 + start;
    offset = (size * frac) / 256;
    lo     = centre - n / 2 + offset;
    hi     = centre + n / 2 + offset;
    if (lo < 0) begin
      hi = hi - lo;
      lo = 0;
    end
    if (hi >= longint'(dim)) lo = lo - (hi - longint'(dim) + 1);
    len = n;
    return lo;
  endfunction

  function automatic crop_t predict_crop(input logic signed [13:0] l, input logic signed [13:0] t,
                                         input logic signed [13:0] r,
                                         input logic signed [13:0] b);
    longint bw, bh, scale, rx, ry, wlen, hlen;
    crop_t  res;
    bw = longint'(r) - longint'(l) + 1;
    bh = longint'(b) - longint'(t) + 1;
    res = '0;
    if (bw <= 0 || bh <= 0) begin
      res.invalid = 1'b1;
      return res;
    end
    scale = longint'(scale_cap);
    rx = fit_scale(frame_w, bw);
    ry = fit_scale(frame_h, bh);
    if (rx < scale) scale = rx;
    if (ry < scale) scale = ry;
    res.left   = clamp_pos(place_span(longint'(l), bw, scale, longint'(shift_x), frame_w, wlen));
    res.top    = clamp_pos(place_span(longint'(t), bh, scale, longint'(shift_y), frame_h, hlen));
    res.width  = wlen[11:0];
    res.height = hlen[11:0];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [11:0] want, input logic [11:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    crop_t want;
    if (rst) begin
      frame_w   = FRAME_WIDTH_RST;
      frame_h   = FRAME_HEIGHT_RST;
      scale_cap = SCALE_LIMIT_RST;
      shift_x   = '0;
      shift_y   = '0;
      crops_due.delete();
    end else begin
      // Prediction uses the registers as they stood before this edge.
      if (in_valid && in_ready)
        crops_due.push_back(predict_crop(box_left, box_top, box_right, box_bottom));
      if (cfg_write) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_w   = cfg_data;
          REG_FRAME_HEIGHT: frame_h   = cfg_data;
          REG_SCALE_LIMIT:  scale_cap = cfg_data;
          REG_SHIFT_X_FRAC: shift_x   = cfg_data[9:0];
          REG_SHIFT_Y_FRAC: shift_y   = cfg_data[9:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (crops_due.size() == 0) begin
          $error("crop result with no box waiting: left %0d top %0d width %0d height %0d",
                 crop_left, crop_top, crop_width, crop_height);
          fails++;
        end else begin
          want = crops_due.pop_front();
          check_field("crop_left", want.left, crop_left);
          check_field("crop_top", want.top, crop_top);
          check_field("crop_width", want.width, crop_width);
          check_field("crop_height", want.height, crop_height);
          check_field("box_invalid", {11'd0, want.invalid}, {11'd0, box_invalid});
          checked++;
          if (want.invalid) invalids++;
        end
      end
    end
    fail_count    <= fails;
    pending       <= crops_due.size();
    checked_count <= checked;
    invalid_count <= invalids;
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

// Top of the crop box calculator testbench. It makes the clock, the single
// reset, the register writes and the face box items, and gives the verdict.
// All prediction and comparison lives in fcb_checker, which sits beside the
// block and watches the same wires.
module tb_top;
  import fcb_pkg::*;

  localparam int PHASE_ITEMS = 235;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [2:0]         cfg_index;
  logic [11:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [13:0] box_left;
  logic signed [13:0] box_top;
  logic signed [13:0] box_right;
  logic signed [13:0] box_bottom;
  logic               out_valid;
  logic               out_ready;
  logic [11:0]        crop_left;
  logic [11:0]        crop_top;
  logic [11:0]        crop_width;
  logic [11:0]        crop_height;
  logic               box_invalid;

  int fail_count;
  int pending;
  int checked_count;
  int invalid_count;

  // Percent of cycles in which the sender holds back an item and the receiver
  // drops out_ready. They change between phases.
  int send_idle_pct;
  int recv_idle_pct;

  // Frame size currently programmed, used to aim random boxes at the frame.
  int cur_fw;
  int cur_fh;
  int sent_items;

  face_crop_box_calc_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .box_left    (box_left),
    .box_top     (box_top),
    .box_right   (box_right),
    .box_bottom  (box_bottom),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .crop_left   (crop_left),
    .crop_top    (crop_top),
    .crop_width  (crop_width),
    .crop_height (crop_height),
    .box_invalid (box_invalid)
  );

  fcb_checker crop_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .box_left      (box_left),
    .box_top       (box_top),
    .box_right     (box_right),
    .box_bottom    (box_bottom),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .crop_left     (crop_left),
    .crop_top      (crop_top),
    .crop_width    (crop_width),
    .crop_height   (crop_height),
    .box_invalid   (box_invalid),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count),
    .invalid_count (invalid_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The receiver decides at every falling edge whether it takes a result in
  // the next cycle. The block sees a steady out_ready at the rising edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Uniform integer in [lo, hi]; hi is never below lo at the call sites.
  function automatic int rnd_span(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Drives one item at a falling edge and holds it until the block takes it.
  // Idle cycles before the item keep in_valid low; once high it stays high,
  // so in_valid is written at most once per falling edge.
  task automatic send_box(input int l, input int t, input int r, input int b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    box_left   <= l[13:0];
    box_top    <= t[13:0];
    box_right  <= r[13:0];
    box_bottom <= b[13:0];
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  // A plausible face span along one axis: mostly well inside the frame, some
  // of it larger than the frame so the fit ratio wins over the scale limit,
  // and some hanging off either edge. A zero frame size still gets spans.
  task automatic gen_axis(input int dim, output int lo, output int hi);
    int d;
    int size;
    d = (dim == 0) ? 64 : dim;
    if ($urandom_range(2) != 0) size = rnd_span(1, (d / 2 > 1) ? d / 2 : 1);
    else size = rnd_span(1, 2 * d);
    lo = rnd_span(-(size / 2), d - size / 2);
    hi = lo + size - 1;
  endtask

  task automatic send_random_box();
    int roll;
    int x0, x1, y0, y1;
    roll = $urandom_range(99);
    gen_axis(cur_fw, x0, x1);
    gen_axis(cur_fh, y0, y1);
    if (roll < 60) begin
      // Keep the well-formed box as generated.
    end else if (roll < 75) begin
      // Raw corners over the whole 14-bit range; about three quarters come out invalid.
      x0 = rnd_span(-8192, 8191);
      x1 = rnd_span(-8192, 8191);
      y0 = rnd_span(-8192, 8191);
      y1 = rnd_span(-8192, 8191);
    end else if (roll < 85) begin
      // Broken box: one axis gets zero or negative size.
      if ($urandom_range(1) != 0) x1 = x0 - rnd_span(1, 4);
      else y1 = y0 - rnd_span(1, 4);
    end else begin
      // Tiny boxes, mostly parked at a corner or edge of the frame.
      case ($urandom_range(2))
        0: x0 = 0;
        1: x0 = cur_fw - 1;
        default: x0 = rnd_span(0, cur_fw);
      endcase
      case ($urandom_range(2))
        0: y0 = 0;
        1: y0 = cur_fh - 1;
        default: y0 = rnd_span(0, cur_fh);
      endcase
      x1 = x0 + rnd_span(0, 3);
      y1 = y0 + rnd_span(0, 3);
    end
    send_box(x0, y0, x1, y1);
  endtask

  // Lowers in_valid and waits for every predicted result to come back. Each
  // item yields exactly one result, so an empty queue means an idle block.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [2:0] index, input int value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value[11:0];
  endtask

  // Writes all five registers back to back; cfg_write stays high throughout
  // and drops once at the end. Shift values go in as two's complement.
  task automatic program_regs(input int fw, input int fh, input int sl,
                              input int sx, input int sy);
    cfg_put(REG_FRAME_WIDTH, fw);
    cfg_put(REG_FRAME_HEIGHT, fh);
    cfg_put(REG_SCALE_LIMIT, sl);
    cfg_put(REG_SHIFT_X_FRAC, sx);
    cfg_put(REG_SHIFT_Y_FRAC, sy);
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_fw = fw;
    cur_fh = fh;
  endtask

  initial begin
    int fw, fh, sl, sx, sy;
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    box_left   = '0;
    box_top    = '0;
    box_right  = '0;
    box_bottom = '0;
    out_ready  = 1'b0;
    sent_items = 0;
    cur_fw     = 640;
    cur_fh     = 480;
    send_idle_pct = 10;
    recv_idle_pct = 72;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed boxes against the reset registers (640 x 480, scale 4.0, no
    // shift): a typical face, the full frame, boxes hanging off each side,
    // single pixels, the extreme corners of the coordinate range, and boxes
    // with zero or negative width or height.
    send_box(300, 200, 340, 250);
    send_box(0, 0, 639, 479);
    send_box(-100, -50, 50, 60);
    send_box(600, 400, 700, 520);
    send_box(0, 0, 0, 0);
    send_box(639, 479, 639, 479);
    send_box(-8192, -8192, 8191, 8191);
    send_box(8191, 8191, 8191, 8191);
    send_box(-8192, -8192, -8192, -8192);
    send_box(8191, 8191, -8192, -8192);
    send_box(10, 10, 9, 40);
    send_box(10, 10, 40, 5);
    send_box(-8192, 0, 8191, 0);
    send_box(100, -8192, 100, 8191);
    wait_drained();

    // Random phases, each under its own register setting. The first two
    // stall mostly on the receiver side, the next two mostly on the sender
    // side, and the last two run without any idling.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          // Reset values written explicitly.
          fw = 640; fh = 480; sl = 1024; sx = 0; sy = 0;
        end
        1: begin
          // Frame and scale registers at their top; shift +1.0 and -1.0.
          fw = 4095; fh = 4095; sl = 4095; sx = 256; sy = -256;
        end
        2: begin
          // Smallest frame and zero scale; shifts the other way round.
          fw = 1; fh = 1; sl = 0; sx = -256; sy = 256;
        end
        3: begin
          fw = rnd_span(1, 4095); fh = rnd_span(1, 4095); sl = rnd_span(0, 4095);
          sx = rnd_span(-256, 256); sy = rnd_span(-256, 256);
        end
        4: begin
          // Zero frame size, which also makes the position clamp act, and
          // shifts at the ends of the 10-bit field, well past one box size.
          fw = 0; fh = 0; sl = rnd_span(256, 4095); sx = -512; sy = 511;
        end
        default: begin
          // Small frames with shifts anywhere in the 10-bit field.
          fw = rnd_span(1, 200); fh = rnd_span(1, 200); sl = rnd_span(0, 4095);
          sx = rnd_span(-512, 511); sy = rnd_span(-512, 511);
        end
      endcase
      if (ph < 2) begin
        send_idle_pct = 10;
        recv_idle_pct = 72;
      end else if (ph < 4) begin
        send_idle_pct = 72;
        recv_idle_pct = 10;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      program_regs(fw, fh, sl, sx, sy);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Halfway through one phase the sender holds off until the block has
        // emptied, so the pipeline refills from nothing mid-stream.
        if (ph == 2 && n == PHASE_ITEMS / 2) wait_drained();
        send_random_box();
      end
      wait_drained();
    end

    // Wait well past the time a result takes to come back, so any stray extra
    // result is caught by the checker.
    repeat (40) @(posedge clk);

    $display("Covered %0d face boxes: reset defaults plus six register settings, %s",
             sent_items, "including zero frame and out-of-range shifts.");
    $display("Compared %0d crop results, %0d of them for invalid boxes, under three idle mixes.",
             checked_count, invalid_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #(2_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
